/* rtl/resistor_ladder_button_decoder_macros.svh */
// assertion macros for the decoder modules, included by the sequencer
`ifndef RESISTOR_LADDER_BUTTON_DECODER_MACROS_SVH
`define RESISTOR_LADDER_BUTTON_DECODER_MACROS_SVH

// checked property, idle while reset is high
`define RLBD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds during reset
`define RLBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rlbd_pkg.sv */
// shared types and constants of the ladder button decoder
package rlbd_pkg;

  localparam int CNT_W     = 4;
  localparam int DEB_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;
  localparam int THR_W     = 16;
  localparam int PAT_W     = 8;
  localparam int SLOT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOWER    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_UPPER    = 4'd3;

  localparam logic [CNT_W-1:0] COUNT_RESET    = 4'd4;
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic zero_count;
    logic last_step;
    logic out_free;
  } status_t;

endpackage

/* rtl/resistor_ladder_button_decoder.sv */
// top level of the ladder button decoder
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in      | in_valid/in_ready   | adc_sample, time_ms
//  out     | out_valid/out_ready | raw_pattern, stable_pattern, stable_changed
//
// a result is loaded into the output register after one compare-subtract
// step per button, n being the saturated button count, then a commit step
// a new sample is taken as soon as the previous result is in the output
// register, even while that beat is still stalled; a second result waits in
// the commit state with in_ready low until the output register frees up
// reset restores button_count 4, debounce_ms 50, thresholds 0, debounce patterns 0
// cfg_ready is always high
module resistor_ladder_button_decoder
  import rlbd_pkg::*;
#(
  parameter int ADC_BITS    = 10,
  parameter int MAX_BUTTONS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADC_BITS-1:0]  adc_sample,
  input  logic [TIME_BITS-1:0] time_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PAT_W-1:0]     raw_pattern,
  output logic [PAT_W-1:0]     stable_pattern,
  output logic                 stable_changed
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  rlbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rlbd_dp #(
    .ADC_BITS    (ADC_BITS),
    .MAX_BUTTONS (MAX_BUTTONS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .adc_sample     (adc_sample),
    .time_ms        (time_ms),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .raw_pattern    (raw_pattern),
    .stable_pattern (stable_pattern),
    .stable_changed (stable_changed)
  );

endmodule

/* rtl/rlbd_ctrl.sv */
// sequencer: accept a sample, walk the buttons, hand the result over
module rlbd_ctrl
  import rlbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

`include "resistor_ladder_button_decoder_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.zero_count ? ST_DONE : ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `RLBD_ASSERT(a_commit_needs_room, clk, rst, cmd.commit |-> status.out_free, "commit into a full output register")
  `RLBD_ASSERT(a_zero_skips_steps, clk, rst, (cmd.load && status.zero_count) |=> !cmd.step, "step issued with no buttons")
  `RLBD_ASSERT(a_one_cmd, clk, rst, $onehot0({cmd.load, cmd.step, cmd.commit}), "more than one command at once")
  `RLBD_ASSERT(a_commit_returns_idle, clk, rst, cmd.commit |=> in_ready, "not ready after commit")

endmodule

/* rtl/rlbd_dp.sv */
// datapath: config registers, threshold walk, debounce state, output register
module rlbd_dp
  import rlbd_pkg::*;
#(
  parameter int ADC_BITS    = 10,
  parameter int MAX_BUTTONS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [ADC_BITS-1:0]   adc_sample,
  input  logic [TIME_BITS-1:0]  time_ms,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PAT_W-1:0]      raw_pattern,
  output logic [PAT_W-1:0]      stable_pattern,
  output logic                  stable_changed
);

  localparam int CW = ((ADC_BITS + 1 > THR_W) ? ADC_BITS + 1 : THR_W) + 1;
  localparam logic [CNT_W-1:0] MAXB = CNT_W'(MAX_BUTTONS);
  localparam logic [4:0] MEXP = 5'(ADC_BITS - 2);

  // configuration
  logic [CNT_W-1:0]   button_count;
  logic [DEB_W-1:0]   debounce_ms;
  logic [CFG_W-1:0]   thr_lower;
  logic [CFG_W-1:0]   thr_upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      button_count <= COUNT_RESET;
      debounce_ms  <= DEBOUNCE_RESET;
      thr_lower    <= '0;
      thr_upper    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BUTTON_COUNT: button_count <= cfg_data[CNT_W-1:0];
        REG_DEBOUNCE_MS:  debounce_ms  <= cfg_data[DEB_W-1:0];
        REG_THR_LOWER:    thr_lower    <= cfg_data;
        REG_THR_UPPER:    thr_upper    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt_sat;
  logic [4:0]       mexp_sh;
  logic [ADC_BITS-1:0] margin_init;

  assign cnt_sat = (button_count > MAXB) ? MAXB : button_count;
  assign mexp_sh = MEXP - 5'(cnt_sat);
  assign margin_init = ({1'b0, cnt_sat} <= MEXP) ? (ADC_BITS'(1) << mexp_sh) : '0;

  // walk registers
  logic [ADC_BITS-1:0]  rem;
  logic [ADC_BITS-1:0]  margin;
  logic [SLOT_W-1:0]    slot;
  logic [PAT_W-1:0]     pattern;
  logic [TIME_BITS-1:0] now;

  logic [2*CFG_W-1:0] thr_all;
  logic [THR_W-1:0]   thr;
  logic [CW-1:0]      rem_x;
  logic [CW-1:0]      thr_x;
  logic [CW-1:0]      lhs;
  logic [CW-1:0]      diff;
  logic               pressed;
  logic [SLOT_W-1:0]  bit_idx;
  logic [CNT_W-1:0]   slot_x;

  assign thr_all = {thr_upper, thr_lower};
  assign thr     = thr_all[{slot, 4'b0000} +: THR_W];
  assign rem_x   = CW'(rem);
  assign thr_x   = CW'(thr);
  // rem > thr - margin, kept unsigned by moving the margin across
  assign lhs     = rem_x + CW'(margin);
  assign pressed = lhs > thr_x;
  assign diff    = rem_x - thr_x;
  assign slot_x  = CNT_W'(slot);
  assign bit_idx = SLOT_W'(cnt_sat - 1'b1 - slot_x);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem     <= adc_sample;
      margin  <= margin_init;
      slot    <= '0;
      pattern <= '0;
      now     <= time_ms;
    end else if (cmd.step) begin
      slot <= slot + 1'b1;
      if (pressed) begin
        pattern[bit_idx] <= 1'b1;
        rem <= (rem_x > thr_x) ? diff[ADC_BITS-1:0] : '0;
      end
    end
  end

  // debounce state
  logic [PAT_W-1:0]     last_raw;
  logic [PAT_W-1:0]     stable_bits;
  logic [TIME_BITS-1:0] change_time;
  logic [TIME_BITS-1:0] change_time_next;
  logic [TIME_BITS-1:0] elapsed;
  logic [PAT_W-1:0]     stable_next;

  assign change_time_next = (pattern != last_raw) ? now : change_time;
  assign elapsed          = now - change_time_next;
  assign stable_next = (elapsed > TIME_BITS'(debounce_ms)) ? pattern : stable_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw    <= '0;
      stable_bits <= '0;
      change_time <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        last_raw    <= pattern;
        stable_bits <= stable_next;
        change_time <= change_time_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      raw_pattern    <= pattern;
      stable_pattern <= stable_next;
      stable_changed <= stable_next != stable_bits;
    end
  end

  assign status.zero_count = cnt_sat == '0;
  assign status.last_step  = slot_x == cnt_sat - 1'b1;
  assign status.out_free   = !out_valid || out_ready;

endmodule

/* bench/ladder_result_checker.sv */
// checker for the ladder button decoder: tracks config beats, predicts each result, compares
module ladder_result_checker
  import rlbd_pkg::*;
#(
  parameter int ADC_BITS    = 10,
  parameter int MAX_BUTTONS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [ADC_BITS-1:0]  adc_sample,
  input  logic [TIME_BITS-1:0] time_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [PAT_W-1:0]     raw_pattern,
  input  logic [PAT_W-1:0]     stable_pattern,
  input  logic                 stable_changed,
  output int unsigned          failures,
  output int unsigned          outstanding
);

  typedef struct packed {
    logic [PAT_W-1:0] raw;
    logic [PAT_W-1:0] stable;
    logic             changed;
  } button_state_t;

  logic [CNT_W-1:0]     btn_count;
  logic [DEB_W-1:0]     hold_ms;
  logic [THR_W-1:0]     slot_thr [8];
  logic [PAT_W-1:0]     prev_raw;
  logic [PAT_W-1:0]     settled;
  logic [TIME_BITS-1:0] change_ms;
  button_state_t        expected_patterns [$];

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    failures++;
  endtask

  // greedy walk from slot 0, each pressed button takes its share off the level
  function automatic logic [PAT_W-1:0] decode_buttons(logic [ADC_BITS-1:0] level_in);
    int n;
    int shift;
    int margin;
    int left;
    int i;
    logic [PAT_W-1:0] pat;
    n = (btn_count > MAX_BUTTONS) ? MAX_BUTTONS : int'(btn_count);
    shift = ADC_BITS - n - 2;
    margin = (shift >= 0 && shift < 30) ? (1 << shift) : 0;
    left = int'(level_in);
    pat = '0;
    for (i = 0; i < n; i++) begin
      if (left > int'(slot_thr[i]) - margin) begin
        pat[n - 1 - i] = 1'b1;
        left = left - int'(slot_thr[i]);
        if (left < 0) left = 0;
      end
    end
    return pat;
  endfunction

  function automatic button_state_t debounce_step(logic [ADC_BITS-1:0] level_in,
                                                  logic [TIME_BITS-1:0] now);
    button_state_t res;
    logic [PAT_W-1:0] was;
    logic [TIME_BITS-1:0] elapsed;
    was = settled;
    res.raw = decode_buttons(level_in);
    if (res.raw != prev_raw) change_ms = now;
    elapsed = now - change_ms;
    if (elapsed > hold_ms) settled = res.raw;
    prev_raw = res.raw;
    res.stable = settled;
    res.changed = (settled != was);
    return res;
  endfunction

  always @(posedge clk) begin
    button_state_t want;
    int s;
    if (rst) begin
      btn_count = COUNT_RESET;
      hold_ms = DEBOUNCE_RESET;
      for (s = 0; s < 8; s++) slot_thr[s] = '0;
      prev_raw = '0;
      settled = '0;
      change_ms = '0;
      expected_patterns.delete();
      failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BUTTON_COUNT: btn_count = cfg_data[CNT_W-1:0];
          REG_DEBOUNCE_MS:  hold_ms = cfg_data[DEB_W-1:0];
          REG_THR_LOWER: begin
            for (s = 0; s < 4; s++) slot_thr[s] = cfg_data[s*THR_W +: THR_W];
          end
          REG_THR_UPPER: begin
            for (s = 0; s < 4; s++) slot_thr[s+4] = cfg_data[s*THR_W +: THR_W];
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_patterns.push_back(debounce_step(adc_sample, time_ms));
      if (out_valid && out_ready) begin
        if (expected_patterns.size() == 0) begin
          flag_mismatch($sformatf("result beat %0h/%0h/%0b with nothing expected",
                                  raw_pattern, stable_pattern, stable_changed));
        end else begin
          want = expected_patterns.pop_front();
          if (raw_pattern !== want.raw)
            flag_mismatch($sformatf("raw_pattern %0h, expected %0h", raw_pattern, want.raw));
          if (stable_pattern !== want.stable)
            flag_mismatch($sformatf("stable_pattern %0h, expected %0h",
                                    stable_pattern, want.stable));
          if (stable_changed !== want.changed)
            flag_mismatch($sformatf("stable_changed %0b, expected %0b",
                                    stable_changed, want.changed));
        end
      end
    end
    outstanding <= expected_patterns.size();
  end

endmodule

/* bench/tb_resistor_ladder_button_decoder.sv */
// testbench top for the ladder button decoder: stimulus, idling and verdict
module tb_resistor_ladder_button_decoder
  import rlbd_pkg::*;
;

  localparam int ADC_W           = 10;
  localparam int TIME_W          = 32;
  localparam int HALF_PERIOD     = 2;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 120;
  localparam int CYCLE_LIMIT     = 400000;

  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd11;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ADC_W-1:0]     adc_sample = '0;
  logic [TIME_W-1:0]    time_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PAT_W-1:0]     raw_pattern;
  logic [PAT_W-1:0]     stable_pattern;
  logic                 stable_changed;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          hold_armed = 1'b0;
  int          idle_pct = 19;
  int          stall_pct = 19;
  logic [THR_W-1:0] drive_thr [8];

  resistor_ladder_button_decoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .time_ms        (time_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .raw_pattern    (raw_pattern),
    .stable_pattern (stable_pattern),
    .stable_changed (stable_changed)
  );

  ladder_result_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .time_ms        (time_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .raw_pattern    (raw_pattern),
    .stable_pattern (stable_pattern),
    .stable_changed (stable_changed),
    .failures       (failures),
    .outstanding    (outstanding)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // count and hold time carry random junk above their fields
  task automatic load_setup(logic [CNT_W-1:0] cnt, logic [DEB_W-1:0] deb);
    logic [CFG_W-1:0] word;
    word = {$urandom, $urandom};
    word[CNT_W-1:0] = cnt;
    write_reg(REG_BUTTON_COUNT, word);
    word = {$urandom, $urandom};
    word[DEB_W-1:0] = deb;
    write_reg(REG_DEBOUNCE_MS, word);
    write_reg(REG_THR_LOWER, {drive_thr[3], drive_thr[2], drive_thr[1], drive_thr[0]});
    write_reg(REG_THR_UPPER, {drive_thr[7], drive_thr[6], drive_thr[5], drive_thr[4]});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(logic [ADC_W-1:0] level, logic [TIME_W-1:0] stamp);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= level;
    time_ms <= stamp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // binary-weighted ladder over the decoded slots, the rest random
  function automatic void fill_ladder(int n);
    int i;
    for (i = 0; i < 8; i++)
      drive_thr[i] = (i < n) ? THR_W'(1024 >> (i + 1)) : THR_W'($urandom);
  endfunction

  function automatic void fill_random();
    int i;
    for (i = 0; i < 8; i++)
      drive_thr[i] = ($urandom_range(9) < 7) ? THR_W'($urandom_range(0, 1023))
                                              : THR_W'($urandom);
  endfunction

  function automatic void fill_all(logic [THR_W-1:0] v);
    int i;
    for (i = 0; i < 8; i++) drive_thr[i] = v;
  endfunction

  // ladder level for a button pattern, with a little converter jitter
  function automatic logic [ADC_W-1:0] level_for(logic [PAT_W-1:0] pat, int n);
    int level;
    int i;
    level = $urandom_range(0, 2);
    for (i = 0; i < n; i++)
      if (pat[n - 1 - i]) level += int'(drive_thr[i]);
    return (level > 1023) ? 10'd1023 : ADC_W'(level);
  endfunction

  initial begin
    logic [TIME_W-1:0] now_ms;
    logic [CNT_W-1:0]  cnt;
    logic [DEB_W-1:0]  deb;
    logic [PAT_W-1:0]  pat;
    logic [PAT_W-1:0]  mask;
    int n;
    int phase;
    int sent;
    int reps;
    int r;
    int hop;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // reset settings: thresholds all zero, so every button reads as pressed
    send_sample(10'd0, 32'd10);
    send_sample(10'd1023, 32'd40);
    send_sample(10'd512, 32'd61);
    send_sample(10'h155, 32'd61);
    send_sample(10'h2aa, 32'hffff_ffff);
    wait_drained();

    // dropped write, then zero button count with no hold time
    fill_all(16'hffff);
    write_reg(REG_SPARE, {$urandom, $urandom});
    load_setup(4'd0, 16'd0);
    send_sample(10'd1023, 32'd100);
    send_sample(10'd0, 32'd101);
    send_sample(10'd511, 32'd102);
    wait_drained();

    // top thresholds with every button, nothing can be pressed
    load_setup(4'd8, 16'd0);
    send_sample(10'd1023, 32'd200);
    wait_drained();

    // count above the maximum saturates to eight
    fill_ladder(8);
    load_setup(4'd15, 16'd0);
    now_ms = 32'd5000;
    foreach (drive_thr[r]) begin
      send_sample(ADC_W'(r * 131), now_ms);
      now_ms++;
    end
    wait_drained();

    // single button, longest hold time
    fill_ladder(1);
    drive_thr[0] = 16'd512;
    load_setup(4'd1, 16'hffff);
    send_sample(10'd385, 32'd1000);
    send_sample(10'd390, 32'd66535);
    send_sample(10'd400, 32'd66536);
    send_sample(10'd383, 32'd66600);
    wait_drained();

    now_ms = $urandom;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin cnt = 4'd8; deb = 16'd0; end
        1: begin cnt = 4'd1; deb = 16'hffff; end
        2: begin cnt = CNT_W'($urandom_range(2, 7)); deb = 16'd5; end
        3: begin cnt = 4'd4; deb = 16'd50; end
        4: begin cnt = 4'd15; deb = DEB_W'($urandom_range(0, 300)); end
        5: begin cnt = CNT_W'($urandom_range(1, 8)); deb = DEB_W'($urandom_range(0, 100)); end
        6: begin cnt = CNT_W'($urandom_range(9, 15)); deb = DEB_W'($urandom_range(0, 40)); end
        default: begin
          cnt = CNT_W'($urandom_range(1, 8));
          deb = DEB_W'($urandom_range(1, 1000));
        end
      endcase
      n = (cnt > 8) ? 8 : int'(cnt);
      mask = (n >= 8) ? 8'hff : PAT_W'((1 << n) - 1);
      if (phase == 5 || phase == 6) fill_random();
      else fill_ladder(n);
      // long clean stretch with no idling on either side
      idle_pct = (phase == 2) ? 0 : 19;
      stall_pct = (phase == 2) ? 0 : 19;
      if (phase == 1) now_ms = 32'hffff_ffff - $urandom_range(0, 200000);
      if (phase == 3) hold_armed = 1'b1;
      load_setup(cnt, deb);

      sent = 0;
      hop = int'(deb) / 3 + 2;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 85) begin
          // a press held over a few samples, sometimes long enough to settle
          pat = PAT_W'($urandom) & mask;
          reps = $urandom_range(1, 6);
          for (r = 0; r < reps; r++) begin
            if ($urandom_range(9) == 0) now_ms += int'(deb) + $urandom_range(1, 5);
            else now_ms += $urandom_range(0, hop);
            send_sample(level_for(pat, n), now_ms);
            sent++;
          end
        end else begin
          if ($urandom_range(1) == 1) now_ms = $urandom;
          else now_ms += $urandom_range(0, hop);
          send_sample(ADC_W'($urandom), now_ms);
          sent++;
        end
      end
      wait_drained();
    end

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
